// ===== sv/sstod_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstod_pkg
// Shared types, codes and helpers for the serial-set time-of-day clock.
// ----------------------------------------------------------------------------
package sstod_pkg;

  localparam int CNT_W   = 7;
  localparam int FRAME_W = 3;
  localparam int DEK_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int GUIDE_W = 3;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'd57;

  localparam logic [CNT_W-1:0] SEC_WRAP  = 7'd60;
  localparam logic [CNT_W-1:0] MIN_WRAP  = 7'd60;
  localparam logic [CNT_W-1:0] HOUR_WRAP = 7'd24;

  localparam logic [FRAME_W-1:0] FP_HOUR_TENS  = 3'd0;
  localparam logic [FRAME_W-1:0] FP_HOUR_UNITS = 3'd1;
  localparam logic [FRAME_W-1:0] FP_MIN_TENS   = 3'd2;
  localparam logic [FRAME_W-1:0] FP_MIN_UNITS  = 3'd3;
  localparam logic [FRAME_W-1:0] FP_SEC_TENS   = 3'd4;
  localparam logic [FRAME_W-1:0] FP_SEC_UNITS  = 3'd5;

  localparam logic [DEK_W-1:0] DEK_PH0 = 2'd0;
  localparam logic [DEK_W-1:0] DEK_PH1 = 2'd1;
  localparam logic [DEK_W-1:0] DEK_PH2 = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] hour;
    logic [CNT_W-1:0] minute;
    logic [CNT_W-1:0] second;
  } clock_time_t;

  typedef struct packed {
    logic [GUIDE_W-1:0] first;
    logic [GUIDE_W-1:0] second;
  } guide_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
  } digits_t;

  function automatic logic [CNT_W-1:0] mul10(input logic [3:0] d);
    mul10 = {d, 3'b000} + {2'b00, d, 1'b0};
  endfunction

  function automatic guide_t guide_pattern(input logic [DEK_W-1:0] p);
    guide_t g;
    unique case (p)
      DEK_PH0: g = '{first: 3'd4, second: 3'd6};
      DEK_PH1: g = '{first: 3'd2, second: 3'd3};
      DEK_PH2: g = '{first: 3'd1, second: 3'd5};
      default: g = '{first: 3'd0, second: 3'd0};
    endcase
    guide_pattern = g;
  endfunction

endpackage

// ===== sv/sstod_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstod_time
// Time, frame position and dekatron phase registers with their update logic.
// ----------------------------------------------------------------------------
module sstod_time (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic                             cmd,
  input  logic [sstod_pkg::BYTE_W-1:0]     rx_byte,
  output sstod_pkg::clock_time_t           time_nxt,
  output sstod_pkg::guide_t                guide
);

  sstod_pkg::clock_time_t             time_r;
  logic [sstod_pkg::FRAME_W-1:0]      frame_r, frame_nxt;
  logic [sstod_pkg::DEK_W-1:0]        dek_r, dek_nxt;

  logic [sstod_pkg::CNT_W-1:0] sec_inc, min_inc, hour_inc;
  logic [sstod_pkg::CNT_W-1:0] d10;
  logic [3:0]                  d;
  logic                        is_digit;
  sstod_pkg::clock_time_t      tick_time, byte_time;

  assign guide = sstod_pkg::guide_pattern(dek_r);

  always_comb begin
    sec_inc  = time_r.second + 7'd1;
    min_inc  = time_r.minute + 7'd1;
    hour_inc = time_r.hour + 7'd1;
    tick_time = time_r;
    if (sec_inc >= sstod_pkg::SEC_WRAP) begin
      tick_time.second = '0;
      if (min_inc >= sstod_pkg::MIN_WRAP) begin
        tick_time.minute = '0;
        tick_time.hour   = (hour_inc >= sstod_pkg::HOUR_WRAP) ? '0 : hour_inc;
      end else begin
        tick_time.minute = min_inc;
      end
    end else begin
      tick_time.second = sec_inc;
    end
  end

  always_comb begin
    d        = 4'(rx_byte - sstod_pkg::ASCII_ZERO);
    d10      = sstod_pkg::mul10(d);
    is_digit = (rx_byte >= sstod_pkg::ASCII_ZERO) && (rx_byte <= sstod_pkg::ASCII_NINE);
    byte_time = time_r;
    if (is_digit) begin
      unique case (frame_r)
        sstod_pkg::FP_HOUR_TENS: begin
          byte_time = '{hour: d10, minute: '0, second: '0};
        end
        sstod_pkg::FP_HOUR_UNITS: begin
          byte_time = '{hour: time_r.hour + {3'b000, d}, minute: '0, second: '0};
        end
        sstod_pkg::FP_MIN_TENS: begin
          byte_time.minute = d10;
          byte_time.second = '0;
        end
        sstod_pkg::FP_MIN_UNITS: begin
          byte_time.minute = time_r.minute + {3'b000, d};
          byte_time.second = '0;
        end
        sstod_pkg::FP_SEC_TENS: begin
          byte_time.second = d10;
        end
        sstod_pkg::FP_SEC_UNITS: begin
          byte_time.second = time_r.second + {3'b000, d};
        end
        default: begin
          byte_time = time_r;
        end
      endcase
    end
  end

  always_comb begin
    time_nxt  = (cmd == sstod_pkg::CMD_TICK) ? tick_time : byte_time;
    frame_nxt = frame_r;
    dek_nxt   = dek_r;
    if (cmd == sstod_pkg::CMD_TICK) begin
      dek_nxt = (dek_r >= sstod_pkg::DEK_PH2) ? sstod_pkg::DEK_PH0 : dek_r + 2'd1;
    end else begin
      frame_nxt = frame_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      frame_r <= '0;
      dek_r   <= '0;
    end else if (step) begin
      time_r  <= time_nxt;
      frame_r <= frame_nxt;
      dek_r   <= dek_nxt;
    end
  end

  a_dek_reachable: assert property (@(posedge clk) disable iff (!rst_n)
    dek_r != 2'd3)
    else $error("dekatron phase left its three-phase cycle");

  a_frame_adv: assert property (@(posedge clk) disable iff (!rst_n)
    step && (cmd == sstod_pkg::CMD_BYTE) |=> frame_r == 3'($past(frame_r) + 3'd1))
    else $error("frame position did not advance on a byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(time_r) && $stable(frame_r) && $stable(dek_r))
    else $error("state changed without a request");

endmodule

// ===== sv/sstod_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstod_digits
// Splits the hour, minute and second counts into capped display digits.
// ----------------------------------------------------------------------------
module sstod_digits (
  input  sstod_pkg::clock_time_t tm,
  output sstod_pkg::digits_t     digits
);

  logic [3:0]                  h_t, m_t, s_t;
  logic [sstod_pkg::CNT_W-1:0] h_rem, m_rem, s_rem;

  always_comb begin
    priority if (tm.hour >= 7'd20) h_t = 4'd2;
    else if (tm.hour >= 7'd10)     h_t = 4'd1;
    else                           h_t = 4'd0;

    priority if (tm.minute >= 7'd50) m_t = 4'd5;
    else if (tm.minute >= 7'd40)     m_t = 4'd4;
    else if (tm.minute >= 7'd30)     m_t = 4'd3;
    else if (tm.minute >= 7'd20)     m_t = 4'd2;
    else if (tm.minute >= 7'd10)     m_t = 4'd1;
    else                             m_t = 4'd0;

    priority if (tm.second >= 7'd50) s_t = 4'd5;
    else if (tm.second >= 7'd40)     s_t = 4'd4;
    else if (tm.second >= 7'd30)     s_t = 4'd3;
    else if (tm.second >= 7'd20)     s_t = 4'd2;
    else if (tm.second >= 7'd10)     s_t = 4'd1;
    else                             s_t = 4'd0;

    h_rem = tm.hour - sstod_pkg::mul10(h_t);
    m_rem = tm.minute - sstod_pkg::mul10(m_t);
    s_rem = tm.second - sstod_pkg::mul10(s_t);

    digits.hour_tens    = h_t[1:0];
    digits.hour_units   = h_rem[3:0];
    digits.minute_tens  = m_t[2:0];
    digits.minute_units = m_rem[3:0];
    digits.second_tens  = s_t[2:0];
    digits.second_units = s_rem[3:0];
  end

endmodule

// ===== sv/serial_set_time_of_day_clock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_set_time_of_day_clock
// 24-hour clock set over a serial byte frame, with dekatron guide outputs.
// ----------------------------------------------------------------------------
// An accepted request is held in the input reg, then in the result reg;
// out_valid rises when the result reg is loaded.
// Throughput: one request per cycle, set by the single-pass update, when
// out_ready is high; its stalls back up through the input register only.
// Reset (rst_n low, synchronous): time 00:00:00, frame position 0,
// dekatron phase 0, both pipeline registers empty.
// ----------------------------------------------------------------------------
module serial_set_time_of_day_clock (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_hour_tens,
  output logic [3:0] out_hour_units,
  output logic [2:0] out_minute_tens,
  output logic [3:0] out_minute_units,
  output logic [2:0] out_second_tens,
  output logic [3:0] out_second_units,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_byte,
  output logic       out_guide_valid,
  output logic [2:0] out_guide_first,
  output logic [2:0] out_guide_second
);

  logic                             in_valid_r;
  logic                             cmd_r;
  logic [sstod_pkg::BYTE_W-1:0]     byte_r;
  logic                             out_valid_r;
  logic                             adv;
  sstod_pkg::clock_time_t           time_nxt;
  sstod_pkg::guide_t                guide;
  sstod_pkg::digits_t               digits_nxt, digits_r;
  logic                             echo_valid_r, guide_valid_r;
  logic [sstod_pkg::BYTE_W-1:0]     echo_byte_r;
  sstod_pkg::guide_t                guide_r;
  logic                             is_tick;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;
  assign is_tick  = (cmd_r == sstod_pkg::CMD_TICK);

  sstod_time u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .cmd      (cmd_r),
    .rx_byte  (byte_r),
    .time_nxt (time_nxt),
    .guide    (guide)
  );

  sstod_digits u_digits (
    .tm     (time_nxt),
    .digits (digits_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      digits_r      <= digits_nxt;
      echo_valid_r  <= !is_tick;
      echo_byte_r   <= is_tick ? '0 : byte_r;
      guide_valid_r <= is_tick;
      guide_r       <= is_tick ? guide : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hour_tens    = digits_r.hour_tens;
  assign out_hour_units   = digits_r.hour_units;
  assign out_minute_tens  = digits_r.minute_tens;
  assign out_minute_units = digits_r.minute_units;
  assign out_second_tens  = digits_r.second_tens;
  assign out_second_units = digits_r.second_units;
  assign out_echo_valid   = echo_valid_r;
  assign out_echo_byte    = echo_byte_r;
  assign out_guide_valid  = guide_valid_r;
  assign out_guide_first  = guide_r.first;
  assign out_guide_second = guide_r.second;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && (echo_valid_r != guide_valid_r))
    else $error("result register not loaded after update");

  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(cmd_r) && $stable(byte_r))
    else $error("pending request lost while stalled");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(digits_r)
      && $stable(echo_byte_r) && $stable(guide_r))
    else $error("result changed while stalled");

endmodule

// ===== tb/tb_serial_set_time_of_day_clock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_set_time_of_day_clock
// Drives ticks and serial set frames into the time-of-day clock and checks
// every result against a cycle-free model of the time, frame and guide state.
// Runs three idle mixes on both channels; a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_serial_set_time_of_day_clock;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 200;
  localparam logic [sstod_pkg::BYTE_W-1:0] CR = 8'h0D;
  localparam logic [sstod_pkg::BYTE_W-1:0] LF = 8'h0A;

  typedef struct packed {
    logic [1:0]                    hour_tens;
    logic [3:0]                    hour_units;
    logic [2:0]                    minute_tens;
    logic [3:0]                    minute_units;
    logic [2:0]                    second_tens;
    logic [3:0]                    second_units;
    logic                          echo_valid;
    logic [sstod_pkg::BYTE_W-1:0]  echo_byte;
    logic                          guide_valid;
    logic [sstod_pkg::GUIDE_W-1:0] guide_first;
    logic [sstod_pkg::GUIDE_W-1:0] guide_second;
  } tod_result_t;

  class tod_clock_mirror;
    logic [sstod_pkg::CNT_W-1:0]   hours;
    logic [sstod_pkg::CNT_W-1:0]   minutes;
    logic [sstod_pkg::CNT_W-1:0]   seconds;
    logic [sstod_pkg::FRAME_W-1:0] frame_pos;
    logic [sstod_pkg::DEK_W-1:0]   phase;
    tod_result_t                   pending_outputs[$];
    int                            errors;

    function new();
      hours     = '0;
      minutes   = '0;
      seconds   = '0;
      frame_pos = '0;
      phase     = '0;
      errors    = 0;
    endfunction

    function int tens_of(logic [sstod_pkg::CNT_W-1:0] v, int cap);
      int t;
      t = int'(v) / 10;
      if (t > cap) t = cap;
      return t;
    endfunction

    function void note_request(logic cmd, logic [sstod_pkg::BYTE_W-1:0] rx);
      tod_result_t r;
      logic [3:0]  d;
      int          t;
      r = '0;
      if (cmd == sstod_pkg::CMD_TICK) begin
        r.guide_valid = 1'b1;
        case (phase)
          sstod_pkg::DEK_PH0: begin
            r.guide_first  = 3'd4;
            r.guide_second = 3'd6;
          end
          sstod_pkg::DEK_PH1: begin
            r.guide_first  = 3'd2;
            r.guide_second = 3'd3;
          end
          sstod_pkg::DEK_PH2: begin
            r.guide_first  = 3'd1;
            r.guide_second = 3'd5;
          end
          default: ;
        endcase
        phase   = (phase >= sstod_pkg::DEK_PH2) ? sstod_pkg::DEK_PH0 : phase + 1'b1;
        seconds = seconds + 1'b1;
        if (seconds >= sstod_pkg::SEC_WRAP) begin
          seconds = '0;
          minutes = minutes + 1'b1;
          if (minutes >= sstod_pkg::MIN_WRAP) begin
            minutes = '0;
            hours   = hours + 1'b1;
            if (hours >= sstod_pkg::HOUR_WRAP) hours = '0;
          end
        end
      end else begin
        r.echo_valid = 1'b1;
        r.echo_byte  = rx;
        if (frame_pos <= sstod_pkg::FP_SEC_UNITS && rx >= sstod_pkg::ASCII_ZERO &&
            rx <= sstod_pkg::ASCII_NINE) begin
          d = 4'(rx - sstod_pkg::ASCII_ZERO);
          case (frame_pos)
            sstod_pkg::FP_HOUR_TENS: begin
              hours   = 7'(10 * d);
              minutes = '0;
              seconds = '0;
            end
            sstod_pkg::FP_HOUR_UNITS: begin
              hours   = hours + 7'(d);
              minutes = '0;
              seconds = '0;
            end
            sstod_pkg::FP_MIN_TENS: begin
              minutes = 7'(10 * d);
              seconds = '0;
            end
            sstod_pkg::FP_MIN_UNITS: begin
              minutes = minutes + 7'(d);
              seconds = '0;
            end
            sstod_pkg::FP_SEC_TENS: seconds = 7'(10 * d);
            default:                seconds = seconds + 7'(d);
          endcase
        end
        frame_pos = frame_pos + 1'b1;
      end
      t = tens_of(hours, 2);
      r.hour_tens    = 2'(t);
      r.hour_units   = 4'(int'(hours) - 10 * t);
      t = tens_of(minutes, 5);
      r.minute_tens  = 3'(t);
      r.minute_units = 4'(int'(minutes) - 10 * t);
      t = tens_of(seconds, 5);
      r.second_tens  = 3'(t);
      r.second_units = 4'(int'(seconds) - 10 * t);
      pending_outputs.push_back(r);
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(tod_result_t got);
      tod_result_t want;
      if (pending_outputs.size() == 0) begin
        report("result with no request pending");
        return;
      end
      want = pending_outputs.pop_front();
      compare_field("hour_tens",    8'(got.hour_tens),    8'(want.hour_tens));
      compare_field("hour_units",   8'(got.hour_units),   8'(want.hour_units));
      compare_field("minute_tens",  8'(got.minute_tens),  8'(want.minute_tens));
      compare_field("minute_units", 8'(got.minute_units), 8'(want.minute_units));
      compare_field("second_tens",  8'(got.second_tens),  8'(want.second_tens));
      compare_field("second_units", 8'(got.second_units), 8'(want.second_units));
      compare_field("echo_valid",   8'(got.echo_valid),   8'(want.echo_valid));
      compare_field("echo_byte",    got.echo_byte,        want.echo_byte);
      compare_field("guide_valid",  8'(got.guide_valid),  8'(want.guide_valid));
      compare_field("guide_first",  8'(got.guide_first),  8'(want.guide_first));
      compare_field("guide_second", 8'(got.guide_second), 8'(want.guide_second));
    endtask
  endclass

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_valid   = 1'b0;
  logic                         in_cmd     = sstod_pkg::CMD_TICK;
  logic [sstod_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic                         out_ready  = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [1:0]                   out_hour_tens;
  logic [3:0]                   out_hour_units;
  logic [2:0]                   out_minute_tens;
  logic [3:0]                   out_minute_units;
  logic [2:0]                   out_second_tens;
  logic [3:0]                   out_second_units;
  logic                         out_echo_valid;
  logic [7:0]                   out_echo_byte;
  logic                         out_guide_valid;
  logic [2:0]                   out_guide_first;
  logic [2:0]                   out_guide_second;

  tod_clock_mirror               tod_mirror = new();
  int                            send_idle_pct = 8;
  int                            recv_idle_pct = 48;
  int                            sent_count = 0;
  int                            idle_cycles = 0;
  logic [sstod_pkg::FRAME_W-1:0] frame_cursor = '0;

  serial_set_time_of_day_clock dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hour_tens    (out_hour_tens),
    .out_hour_units   (out_hour_units),
    .out_minute_tens  (out_minute_tens),
    .out_minute_units (out_minute_units),
    .out_second_tens  (out_second_tens),
    .out_second_units (out_second_units),
    .out_echo_valid   (out_echo_valid),
    .out_echo_byte    (out_echo_byte),
    .out_guide_valid  (out_guide_valid),
    .out_guide_first  (out_guide_first),
    .out_guide_second (out_guide_second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : monitor
    tod_result_t seen;
    seen = '{out_hour_tens, out_hour_units, out_minute_tens, out_minute_units,
             out_second_tens, out_second_units, out_echo_valid, out_echo_byte,
             out_guide_valid, out_guide_first, out_guide_second};
    if (rst_n) begin
      if (out_valid && out_ready) tod_mirror.check_result(seen);
      if (in_valid && in_ready) tod_mirror.note_request(in_cmd, in_rx_byte);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_request(input logic cmd, input logic [sstod_pkg::BYTE_W-1:0] rx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_rx_byte <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    if (cmd == sstod_pkg::CMD_BYTE) frame_cursor = frame_cursor + 1'b1;
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      send_request(sstod_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(sstod_pkg::CMD_BYTE, s[i]);
  endtask

  function automatic logic [sstod_pkg::BYTE_W-1:0] non_digit();
    logic [sstod_pkg::BYTE_W-1:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b >= sstod_pkg::ASCII_ZERO && b <= sstod_pkg::ASCII_NINE);
    return b;
  endfunction

  task automatic align_frame();
    while (frame_cursor != sstod_pkg::FP_HOUR_TENS) begin
      send_request(sstod_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // HHMMSS request frame, mostly legal times, often just before a carry
  task automatic send_random_frame();
    logic [sstod_pkg::BYTE_W-1:0] fb [8];
    int                           h, m, s, kind;
    align_frame();
    kind = $urandom_range(0, 9);
    h = $urandom_range(0, 23);
    m = $urandom_range(0, 59);
    s = $urandom_range(0, 59);
    if (kind < 3) begin
      h = 23;
      m = 59;
      s = $urandom_range(50, 59);
    end else if (kind < 5) begin
      m = 59;
      s = $urandom_range(55, 59);
    end
    fb[0] = sstod_pkg::ASCII_ZERO + 8'(h / 10);
    fb[1] = sstod_pkg::ASCII_ZERO + 8'(h % 10);
    fb[2] = sstod_pkg::ASCII_ZERO + 8'(m / 10);
    fb[3] = sstod_pkg::ASCII_ZERO + 8'(m % 10);
    fb[4] = sstod_pkg::ASCII_ZERO + 8'(s / 10);
    fb[5] = sstod_pkg::ASCII_ZERO + 8'(s % 10);
    if (kind == 9) begin
      for (int i = 0; i < 6; i++) fb[i] = sstod_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
    end
    fb[6] = CR;
    fb[7] = LF;
    if ($urandom_range(0, 99) < 15) fb[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
    foreach (fb[i]) send_request(sstod_pkg::CMD_BYTE, fb[i]);
  endtask

  // one field keeps adding units digits to its 7-bit count, which may wrap
  task automatic send_stacked_frames();
    int lane, n;
    align_frame();
    send_text("999999");
    send_request(sstod_pkg::CMD_BYTE, CR);
    send_request(sstod_pkg::CMD_BYTE, LF);
    lane = $urandom_range(0, 2);
    n = $urandom_range(3, 5);
    for (int f = 0; f < n; f++) begin
      for (int p = 0; p < 6; p++) begin
        if (p == 2 * lane + 1) begin
          send_request(sstod_pkg::CMD_BYTE, sstod_pkg::ASCII_ZERO + 8'($urandom_range(5, 9)));
        end else begin
          send_request(sstod_pkg::CMD_BYTE, non_digit());
        end
      end
      send_request(sstod_pkg::CMD_BYTE, CR);
      send_request(sstod_pkg::CMD_BYTE, LF);
    end
  endtask

  task automatic run_random(input int quota);
    int stop, pick;
    stop = sent_count + quota;
    while (sent_count < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_random_frame();
        send_ticks($urandom_range(1, 12));
      end else if (pick < 55) begin
        send_stacked_frames();
      end else if (pick < 80) begin
        send_ticks(($urandom_range(0, 9) == 0) ? $urandom_range(60, 130)
                                               : $urandom_range(1, 20));
      end else begin
        for (int i = $urandom_range(1, 5); i > 0; i--) begin
          if ($urandom_range(0, 1)) begin
            send_request(sstod_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
          end else begin
            send_request(sstod_pkg::CMD_BYTE, sstod_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // out-of-range time, then a tick that carries through every field
    send_text("999999");
    send_request(sstod_pkg::CMD_BYTE, CR);
    send_request(sstod_pkg::CMD_BYTE, LF);
    send_ticks(3);
    // bytes just outside the digit range, digit in the ignored tail
    send_request(sstod_pkg::CMD_BYTE, sstod_pkg::ASCII_ZERO - 8'd1);
    send_request(sstod_pkg::CMD_BYTE, sstod_pkg::ASCII_ZERO);
    send_request(sstod_pkg::CMD_BYTE, sstod_pkg::ASCII_NINE + 8'd1);
    send_request(sstod_pkg::CMD_BYTE, sstod_pkg::ASCII_ZERO);
    send_request(sstod_pkg::CMD_BYTE, 8'hFF);
    send_request(sstod_pkg::CMD_BYTE, sstod_pkg::ASCII_NINE);
    send_request(sstod_pkg::CMD_BYTE, sstod_pkg::ASCII_ZERO + 8'd7);
    send_request(sstod_pkg::CMD_BYTE, 8'h00);
    // midnight rollover
    send_text("235959");
    send_ticks(1);

    run_random(PHASE_ITEMS);
    send_idle_pct = 48;
    recv_idle_pct = 8;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);
    in_valid <= 1'b0;

    while (tod_mirror.pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tod_mirror.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
